/* design/hrlt_pkg.sv */
// Shared types and constants for the hierarchical resource lock table.
// Holds operation and status codes, sequencer states and default sizes.
// No dependencies.
package hrlt_pkg;

    // Width of resource and parent ids on the item ports
    localparam int ID_W = 8;

    // Default table size and hold counter width
    localparam int NUM_RESOURCES_DEF = 256;
    localparam int HOLD_BITS_DEF     = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_FULL = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK_SELF,
        S_CHECK_ANC,
        S_WALK_SELF,
        S_WALK_ANC,
        S_RESP
    } state_t;

endpackage

/* design/hierarchical_resource_lock_table_core.sv */
// Hierarchical resource lock table: tree of resources with lock bits and hold counts.
// One table memory, walked one tree level per cycle by a small sequencer.
// Depends on hrlt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: operation, resource_id,
//   parent_id, has_parent. An item is taken on a clock edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall) returns exactly one item
//   per input item: granted, new_id, status.
//   Add, a refused lock or unlock of a bad id and an unused operation are decided
//   in decode and then answered; unlock clears the resource's own lock, then lowers
//   each ancestor's hold in turn; a successful lock checks the resource and each
//   ancestor for a lock, then sets its own lock and raises each ancestor's hold; a
//   refused lock stops at the busy resource or the first locked ancestor. The pace
//   is set by the table memory's single read port: the sequencer reads one ancestor
//   per cycle, once to check for a locked ancestor and once more to set the lock
//   and adjust the holds. One item is in work at a time; in_stall is high from
//   accept until its result is loaded, so none is taken while one is in work.
//   A finished result waits in the output register while out_stall is high; the next
//   item is taken meanwhile and its own result waits in the sequencer.
//   Reset clears the resource count and all control state. Table entries are written
//   by add before they can be addressed, so the memory needs no clearing pass.
module hierarchical_resource_lock_table_core #(
    parameter int NUM_RESOURCES = hrlt_pkg::NUM_RESOURCES_DEF,
    parameter int HOLD_BITS     = hrlt_pkg::HOLD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [hrlt_pkg::ID_W-1:0] resource_id,
    input  logic [hrlt_pkg::ID_W-1:0] parent_id,
    input  logic                      has_parent,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      granted,
    output logic [hrlt_pkg::ID_W-1:0] new_id,
    output logic [1:0]                status
);
    import hrlt_pkg::*;

    localparam int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int CNT_W = $clog2(NUM_RESOURCES + 1);
    localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    // Table memories, one row per resource
    logic                 lock_mem   [NUM_RESOURCES];
    logic [HOLD_BITS-1:0] hold_mem   [NUM_RESOURCES];
    logic                 pval_mem   [NUM_RESOURCES];
    logic [IDX_W-1:0]     parent_mem [NUM_RESOURCES];

    // Registered read data
    logic                 lock_rd_reg;
    logic [HOLD_BITS-1:0] hold_rd_reg;
    logic                 pval_rd_reg;
    logic [IDX_W-1:0]     par_rd_reg;

    // Memory port controls
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 add_we;
    logic                 lock_we;
    logic                 lock_wd;
    logic                 hold_we;
    logic [HOLD_BITS-1:0] hold_wd;
    logic [IDX_W-1:0]     wr_addr;

    // Sequencer and item registers
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ID_W-1:0]      rid_reg, rid_next;
    logic [ID_W-1:0]      pid_reg, pid_next;
    logic                 haspar_reg, haspar_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;

    // Pending result
    logic                 res_granted_reg, res_granted_next;
    logic [ID_W-1:0]      res_new_id_reg, res_new_id_next;
    status_t              res_status_reg, res_status_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic                 granted_reg, granted_next;
    logic [ID_W-1:0]      new_id_reg, new_id_next;
    status_t              status_reg, status_next;

    // Widened ids and table indexes
    logic [CMP_W-1:0]     rid_wide;
    logic [CMP_W-1:0]     pid_wide;
    logic [CMP_W-1:0]     count_wide;
    logic [IDX_W-1:0]     rid_idx;
    logic [IDX_W-1:0]     pid_idx;
    logic [IDX_W-1:0]     count_idx;
    logic                 table_full;
    logic                 out_free;

    assign rid_wide   = CMP_W'(rid_reg);
    assign pid_wide   = CMP_W'(pid_reg);
    assign count_wide = CMP_W'(count_reg);
    assign rid_idx    = rid_wide[IDX_W-1:0];
    assign pid_idx    = pid_wide[IDX_W-1:0];
    assign count_idx  = count_wide[IDX_W-1:0];
    assign table_full = (count_reg == CNT_W'(NUM_RESOURCES));
    assign out_free   = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;
    assign new_id    = new_id_reg;
    assign status    = status_reg;

    // Table memory: one read port, one write port per field
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lock_rd_reg <= lock_mem[rd_addr];
            hold_rd_reg <= hold_mem[rd_addr];
            pval_rd_reg <= pval_mem[rd_addr];
            par_rd_reg  <= parent_mem[rd_addr];
        end
        if (add_we)
        begin
            pval_mem[wr_addr]   <= haspar_reg;
            parent_mem[wr_addr] <= haspar_reg ? pid_idx : '0;
        end
        if (lock_we)
        begin
            lock_mem[wr_addr] <= lock_wd;
        end
        if (hold_we)
        begin
            hold_mem[wr_addr] <= hold_wd;
        end
    end

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_NONE;
            rid_reg         <= '0;
            pid_reg         <= '0;
            haspar_reg      <= 1'b0;
            count_reg       <= '0;
            cur_reg         <= '0;
            res_granted_reg <= 1'b0;
            res_new_id_reg  <= '0;
            res_status_reg  <= ST_OK;
            out_valid_reg   <= 1'b0;
            granted_reg     <= 1'b0;
            new_id_reg      <= '0;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            rid_reg         <= rid_next;
            pid_reg         <= pid_next;
            haspar_reg      <= haspar_next;
            count_reg       <= count_next;
            cur_reg         <= cur_next;
            res_granted_reg <= res_granted_next;
            res_new_id_reg  <= res_new_id_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            granted_reg     <= granted_next;
            new_id_reg      <= new_id_next;
            status_reg      <= status_next;
        end
    end

    // Sequencer: next state, memory controls and results
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        rid_next         = rid_reg;
        pid_next         = pid_reg;
        haspar_next      = haspar_reg;
        count_next       = count_reg;
        cur_next         = cur_reg;
        res_granted_next = res_granted_reg;
        res_new_id_next  = res_new_id_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        granted_next     = granted_reg;
        new_id_next      = new_id_reg;
        status_next      = status_reg;

        rd_en   = 1'b0;
        rd_addr = cur_reg;
        add_we  = 1'b0;
        lock_we = 1'b0;
        lock_wd = 1'b0;
        hold_we = 1'b0;
        hold_wd = '0;
        wr_addr = cur_reg;

        // Drop a result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(operation);
                    rid_next    = resource_id;
                    pid_next    = parent_id;
                    haspar_next = has_parent;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_granted_next = 1'b0;
                res_new_id_next  = '0;
                res_status_next  = ST_BAD;
                state_next       = S_RESP;
                cur_next         = rid_idx;
                rd_addr          = rid_idx;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (table_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else if (haspar_reg && (pid_wide >= count_wide))
                        begin
                            res_status_next = ST_BAD;
                        end
                        else
                        begin
                            // Write the new row: unlocked, no holds
                            wr_addr          = count_idx;
                            add_we           = 1'b1;
                            lock_we          = 1'b1;
                            lock_wd          = 1'b0;
                            hold_we          = 1'b1;
                            hold_wd          = '0;
                            count_next       = CNT_W'(count_reg + 1'b1);
                            res_granted_next = 1'b1;
                            res_new_id_next  = count_wide[ID_W-1:0];
                            res_status_next  = ST_OK;
                        end
                    end
                    OP_LOCK:
                    begin
                        if (rid_wide < count_wide)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_CHECK_SELF;
                        end
                    end
                    OP_UNLOCK:
                    begin
                        if (rid_wide < count_wide)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_WALK_SELF;
                        end
                    end
                    OP_NONE:
                    begin
                        res_status_next = ST_BAD;
                    end
                endcase
            end

            S_CHECK_SELF:
            begin
                if (lock_rd_reg || (hold_rd_reg != '0))
                begin
                    res_status_next = ST_BUSY;
                    state_next      = S_RESP;
                end
                else if (pval_rd_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = par_rd_reg;
                    cur_next   = par_rd_reg;
                    state_next = S_CHECK_ANC;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rid_idx;
                    cur_next   = rid_idx;
                    state_next = S_WALK_SELF;
                end
            end

            // Climb the ancestors looking for a lock
            S_CHECK_ANC:
            begin
                if (lock_rd_reg)
                begin
                    res_status_next = ST_BUSY;
                    state_next      = S_RESP;
                end
                else if (pval_rd_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = par_rd_reg;
                    cur_next = par_rd_reg;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rid_idx;
                    cur_next   = rid_idx;
                    state_next = S_WALK_SELF;
                end
            end

            // Set or clear the resource's own lock
            S_WALK_SELF:
            begin
                wr_addr          = rid_idx;
                lock_we          = 1'b1;
                lock_wd          = (op_reg == OP_LOCK);
                res_granted_next = 1'b1;
                res_status_next  = ST_OK;
                if (pval_rd_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = par_rd_reg;
                    cur_next   = par_rd_reg;
                    state_next = S_WALK_ANC;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // Raise or lower each ancestor's hold, saturating
            S_WALK_ANC:
            begin
                wr_addr = cur_reg;
                hold_we = 1'b1;
                hold_wd = hold_rd_reg;
                if (op_reg == OP_LOCK)
                begin
                    if (!(&hold_rd_reg))
                    begin
                        hold_wd = hold_rd_reg + 1'b1;
                    end
                end
                else if (hold_rd_reg != '0)
                begin
                    hold_wd = hold_rd_reg - 1'b1;
                end
                if (pval_rd_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = par_rd_reg;
                    cur_next = par_rd_reg;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // Hand the result to the output register when it is free
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = res_granted_reg;
                    new_id_next    = res_new_id_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* dv/lock_table_sb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the hierarchical resource lock table: table predictor and reply checker.
// Depends on hrlt_pkg for id width, default sizes, operation and status codes.
package lock_table_sb_pkg;

    import hrlt_pkg::*;

    localparam int TABLE_SIZE = NUM_RESOURCES_DEF;
    localparam int HOLD_W     = HOLD_BITS_DEF;

    typedef struct packed {
        logic            granted;
        logic [ID_W-1:0] new_id;
        status_t         status;
    } lock_reply_t;

    class lock_table_scoreboard;

        bit                locked  [TABLE_SIZE];
        logic [HOLD_W-1:0] holds   [TABLE_SIZE];
        bit                has_up  [TABLE_SIZE];
        logic [ID_W-1:0]   up_id   [TABLE_SIZE];
        int unsigned       table_count;
        lock_reply_t       pending_replies[$];
        int                mismatch_count;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                locked[i] = 1'b0;
                holds[i]  = '0;
                has_up[i] = 1'b0;
                up_id[i]  = '0;
            end
            table_count    = 0;
            mismatch_count = 0;
        endfunction

        // Walk toward the root and stop at the first locked ancestor
        function bit ancestor_is_locked(int unsigned id);
            int unsigned cur;
            cur = id;
            while (has_up[cur])
            begin
                cur = up_id[cur];
                if (locked[cur])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Raise or lower every ancestor's hold, saturating at both ends
        function void shift_holds(int unsigned id, bit raise);
            int unsigned cur;
            cur = id;
            while (has_up[cur])
            begin
                cur = up_id[cur];
                if (raise)
                begin
                    if (holds[cur] != '1)
                        holds[cur] = holds[cur] + 1'b1;
                end
                else if (holds[cur] != '0)
                    holds[cur] = holds[cur] - 1'b1;
            end
        endfunction

        // Apply one item to the table copy and return the reply it should give
        function lock_reply_t predict_reply(op_t op, logic [ID_W-1:0] rid,
                                            logic [ID_W-1:0] pid, logic hp);
            lock_reply_t r;
            r.granted = 1'b0;
            r.new_id  = '0;
            r.status  = ST_BAD;
            case (op)
                OP_ADD:
                begin
                    if (table_count >= TABLE_SIZE)
                        r.status = ST_FULL;
                    else if (hp && pid >= table_count)
                        r.status = ST_BAD;
                    else
                    begin
                        locked[table_count] = 1'b0;
                        holds[table_count]  = '0;
                        has_up[table_count] = hp;
                        up_id[table_count]  = hp ? pid : '0;
                        r.granted = 1'b1;
                        r.new_id  = ID_W'(table_count);
                        r.status  = ST_OK;
                        table_count++;
                    end
                end
                OP_LOCK:
                begin
                    if (rid >= table_count)
                        r.status = ST_BAD;
                    else if (locked[rid] || holds[rid] != '0 || ancestor_is_locked(rid))
                        r.status = ST_BUSY;
                    else
                    begin
                        locked[rid] = 1'b1;
                        shift_holds(rid, 1'b1);
                        r.granted = 1'b1;
                        r.status  = ST_OK;
                    end
                end
                OP_UNLOCK:
                begin
                    if (rid >= table_count)
                        r.status = ST_BAD;
                    else
                    begin
                        // an unlock of a free resource still lowers the holds
                        locked[rid] = 1'b0;
                        shift_holds(rid, 1'b0);
                        r.granted = 1'b1;
                        r.status  = ST_OK;
                    end
                end
                default:
                    ;
            endcase
            return r;
        endfunction

        function void note_request(op_t op, logic [ID_W-1:0] rid,
                                   logic [ID_W-1:0] pid, logic hp);
            pending_replies.push_back(predict_reply(op, rid, pid, hp));
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        // Compare one accepted reply with the oldest prediction
        task check_reply(logic g, logic [ID_W-1:0] nid, logic [1:0] st);
            lock_reply_t want;
            if (pending_replies.size() == 0)
            begin
                report_mismatch($sformatf("reply with none outstanding: granted %0d new_id %0d status %0d",
                                          g, nid, st));
                return;
            end
            want = pending_replies.pop_front();
            if (g !== want.granted)
                report_mismatch($sformatf("granted %0d, want %0d", g, want.granted));
            if (nid !== want.new_id)
                report_mismatch($sformatf("new_id %0d, want %0d", nid, want.new_id));
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, want %s", st, want.status.name()));
        endtask

    endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top-level testbench for hierarchical_resource_lock_table_core: drivers, stall control, checks.
// Depends on hrlt_pkg and lock_table_sb_pkg.
module tb_top;

    import hrlt_pkg::*;
    import lock_table_sb_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 64;
    localparam int RANDOM_ITEMS = 1820;

    logic            clk;
    logic            rst_n       = 1'b0;
    logic            in_valid    = 1'b0;
    logic            in_stall;
    logic [1:0]      operation   = '0;
    logic [ID_W-1:0] resource_id = '0;
    logic [ID_W-1:0] parent_id   = '0;
    logic            has_parent  = 1'b0;
    logic            out_valid;
    logic            out_stall   = 1'b0;
    logic            granted;
    logic [ID_W-1:0] new_id;
    logic [1:0]      status;

    lock_table_scoreboard sb;

    int     items_sent  = 0;
    bit     steady_send = 1'b0;
    logic   hold_off    = 1'b0;
    int     stall_run   = 0;
    logic   stall_level = 1'b0;
    longint cycle_count = 0;

    hierarchical_resource_lock_table_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .resource_id(resource_id),
        .parent_id  (parent_id),
        .has_parent (has_parent),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted    (granted),
        .new_id     (new_id),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short delays, now and then a long one
    function automatic int pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // Offer one item and hold it until the block takes it
    task send_item(op_t op, logic [ID_W-1:0] rid, logic [ID_W-1:0] pid, logic hp);
        int gap;
        gap = steady_send ? 0 : pick_delay();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        resource_id <= rid;
        parent_id   <= pid;
        has_parent  <= hp;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(op, rid, pid, hp);
        items_sent++;
    endtask

    // Mostly live locks and unlocks over a growing tree, with some noise
    task run_random_items(int count);
        int              r;
        int              m;
        int              start;
        bit              found;
        logic [ID_W-1:0] rid;
        logic [ID_W-1:0] pid;
        logic            hp;
        for (int n = 0; n < count; n++)
        begin
            steady_send = (n % 300) < 40;
            r   = $urandom_range(99);
            rid = ID_W'($urandom);
            pid = ID_W'($urandom);
            hp  = 1'($urandom);
            if (r < 18)
            begin
                m = $urandom_range(9);
                if (sb.table_count == 0 || m < 2)
                    hp = 1'b0;
                else if (m < 5)
                begin
                    // hang the new resource under the most recently added one
                    hp  = 1'b1;
                    pid = ID_W'(sb.table_count - 1);
                end
                else if (m < 9)
                begin
                    hp  = 1'b1;
                    pid = ID_W'($urandom_range(sb.table_count - 1));
                end
                else
                begin
                    hp = 1'b1;
                    if (sb.table_count < TABLE_SIZE)
                        pid = ID_W'($urandom_range(TABLE_SIZE - 1, sb.table_count));
                end
                send_item(OP_ADD, rid, pid, hp);
            end
            else if (r < 92)
            begin
                if (sb.table_count > 0)
                    rid = ID_W'($urandom_range(sb.table_count - 1));
                if (r < 55)
                    send_item(OP_LOCK, rid, pid, hp);
                else
                begin
                    // prefer releasing something that is actually locked
                    if (sb.table_count > 0 && $urandom_range(1))
                    begin
                        start = $urandom_range(sb.table_count - 1);
                        found = 1'b0;
                        for (int k = 0; k < sb.table_count && !found; k++)
                        begin
                            if (sb.locked[(start + k) % sb.table_count])
                            begin
                                rid   = ID_W'((start + k) % sb.table_count);
                                found = 1'b1;
                            end
                        end
                    end
                    send_item(OP_UNLOCK, rid, pid, hp);
                end
            end
            else if (r < 96)
                send_item(OP_NONE, rid, pid, hp);
            else if (r < 98)
                send_item(OP_LOCK, rid, pid, hp);
            else
                send_item(OP_UNLOCK, rid, pid, hp);
        end
        steady_send = 1'b0;
    endtask

    // Main sequence: reset, directed items, random items, then fill the table
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table refuses everything
        send_item(OP_LOCK,   8'h00, 8'h00, 1'b0);
        send_item(OP_UNLOCK, 8'h00, 8'h00, 1'b0);
        send_item(OP_ADD,    8'h00, 8'h00, 1'b1);
        // root ignores parent_id; chain 0 <- 1 <- 2
        send_item(OP_ADD,    8'hFF, 8'hFF, 1'b0);
        send_item(OP_ADD,    8'h00, 8'h00, 1'b1);
        send_item(OP_ADD,    8'h00, 8'h01, 1'b1);
        // parent not yet added
        send_item(OP_ADD,    8'h00, 8'h03, 1'b1);
        send_item(OP_ADD,    8'h00, 8'hFF, 1'b1);
        // lock leaf, then relock, lock held parent
        send_item(OP_LOCK,   8'h02, 8'h00, 1'b0);
        send_item(OP_LOCK,   8'h02, 8'h00, 1'b0);
        send_item(OP_LOCK,   8'h01, 8'h00, 1'b0);
        // child of locked resource
        send_item(OP_ADD,    8'h00, 8'h02, 1'b1);
        send_item(OP_LOCK,   8'h03, 8'h00, 1'b0);
        // unlock, then unlock again with holds already at zero
        send_item(OP_UNLOCK, 8'h02, 8'h00, 1'b0);
        send_item(OP_UNLOCK, 8'h02, 8'h00, 1'b0);
        send_item(OP_LOCK,   8'h03, 8'h00, 1'b0);
        send_item(OP_LOCK,   8'h00, 8'h00, 1'b0);
        send_item(OP_UNLOCK, 8'h03, 8'h00, 1'b0);
        send_item(OP_LOCK,   8'h00, 8'h00, 1'b0);
        // far ancestor locked
        send_item(OP_LOCK,   8'h02, 8'h00, 1'b0);
        send_item(OP_UNLOCK, 8'h00, 8'h00, 1'b0);
        // unused operation and out-of-range ids
        send_item(OP_NONE,   8'hFF, 8'hFF, 1'b1);
        send_item(OP_LOCK,   8'hFF, 8'h00, 1'b0);
        send_item(OP_UNLOCK, 8'h80, 8'h00, 1'b0);

        run_random_items(RANDOM_ITEMS);

        // fill the table, then hit the full case and the top id
        while (sb.table_count < TABLE_SIZE)
            send_item(OP_ADD, 8'h00, ID_W'($urandom_range(sb.table_count - 1)), 1'b1);
        send_item(OP_ADD,    8'hFF, 8'hFF, 1'b1);
        send_item(OP_ADD,    8'h00, 8'h00, 1'b0);
        send_item(OP_LOCK,   8'hFF, 8'h00, 1'b0);
        send_item(OP_UNLOCK, 8'hFF, 8'h00, 1'b0);
        in_valid <= 1'b0;

        // drain outstanding replies, then watch for strays
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Check replies and drive out_stall in runs of random length
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_reply(granted, new_id, status);
            if (stall_run == 0)
            begin
                stall_level = ($urandom_range(99) < 35);
                stall_run   = pick_delay() + 1;
            end
            stall_run--;
            out_stall <= hold_off || stall_level;
        end
    end

    // Hold off the receiver for a long stretch so the block backs up
    initial
    begin
        while (items_sent < 600)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // End the run if it overstays the cycle budget
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
design/hrlt_pkg.sv
design/hierarchical_resource_lock_table_core.sv
dv/lock_table_sb_pkg.sv
dv/tb_top.sv
